/* rtl/cpa_pkg.sv */
// Shared types and constants for the class pool allocator.
// Used by cpa_ctrl, cpa_datapath and class_pool_allocator_fifo; no dependencies.
package cpa_pkg;

	// Fixed geometry set by the field widths of the beats
	localparam int NUM_CLASSES = 5;
	localparam int MAX_UNITS   = 16;
	localparam int CLASS_W     = 3;
	localparam int SLOT_W      = 4;
	localparam int UNIT_W      = 7;
	localparam int STATUS_W    = 3;
	localparam int SIZE_W      = 5;
	localparam int REG_IDX_W   = 3;

	// Operation carried on s_tuser
	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// Result kind carried on m_tuser
	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 3'd0,
		ST_QUEUED  = 3'd1,
		ST_FREED   = 3'd2,
		ST_HANDED  = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EVAL,
		CS_READ
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic item_ok;
		logic need_read;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/cpa_ctrl.sv */
// Sequencing controller of the class pool allocator.
// Depends on cpa_pkg; drives the load and commit commands of cpa_datapath.
module cpa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  cpa_pkg::dp_status_t   stat,
	output cpa_pkg::ctrl_cmd_t    cmd
);
	import cpa_pkg::*;

	ctrl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			CS_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = CS_EVAL;
				end
			end
			CS_EVAL: begin
				if (!stat.item_ok) begin
					// drop an item for a bad class or slot
					state_d = CS_IDLE;
				end else if (stat.need_read) begin
					state_d = CS_READ;
				end else if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = CS_IDLE;
				end
			end
			CS_READ: begin
				// waiter tag is now in the read register
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

endmodule

/* rtl/cpa_datapath.sv */
// Datapath of the class pool allocator: unit-count registers, busy maps,
// per-class wait queues in one tag memory, and the result register. Depends on cpa_pkg.
module cpa_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 8,
	parameter int S_DATA_W    = 16,
	parameter int M_DATA_W    = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cpa_pkg::ctrl_cmd_t               cmd,
	output cpa_pkg::dp_status_t              stat,
	input  logic [S_DATA_W-1:0]              s_tdata,
	input  logic                             s_tuser,
	input  logic                             cfg_we,
	input  logic [cpa_pkg::REG_IDX_W-1:0]    cfg_idx,
	input  logic [cpa_pkg::SIZE_W-1:0]       cfg_wdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [M_DATA_W-1:0]              m_tdata,
	output logic [cpa_pkg::STATUS_W-1:0]     m_tuser
);
	import cpa_pkg::*;

	localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int CLS_W     = $clog2(NUM_CLASSES);

	// Configuration and allocation state
	logic [SIZE_W-1:0]    units_q [NUM_CLASSES];
	logic [MAX_UNITS-1:0] occ_q   [NUM_CLASSES];
	logic [QPTR_W-1:0]    head_q  [NUM_CLASSES];
	logic [QPTR_W-1:0]    tail_q  [NUM_CLASSES];
	logic [QCNT_W-1:0]    count_q [NUM_CLASSES];
	logic [TAG_BITS-1:0]  wait_mem [MEM_DEPTH];
	logic [TAG_BITS-1:0]  rd_tag_q;

	// Item under work
	op_t                 op_q;
	logic [CLASS_W-1:0]  cn_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [SLOT_W-1:0]   slot_q;

	// Result register
	logic                m_valid_q;
	status_t             res_status_q;
	logic [TAG_BITS-1:0] res_tag_q;
	logic [UNIT_W-1:0]   res_unit_q;
	logic [SLOT_W-1:0]   res_slot_q;

	// Evaluation
	logic                 cls_valid;
	logic [CLS_W-1:0]     cls;
	logic [SIZE_W-1:0]    size [NUM_CLASSES];
	logic [UNIT_W-1:0]    base [NUM_CLASSES];
	logic [MAX_UNITS-1:0] free_bits;
	logic                 found;
	logic [SLOT_W-1:0]    free_idx;
	logic                 q_full;
	logic                 q_empty;
	logic                 slot_ok;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]    cls_ofs;
	logic [QPTR_W-1:0]    head_next;
	logic [QPTR_W-1:0]    tail_next;
	logic                 do_grant;
	logic                 do_queue;
	logic                 do_free;
	logic                 do_hand;

	// Clamp class sizes and form the global unit bases
	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			size[c] = (units_q[c] > SIZE_W'(MAX_UNITS)) ? SIZE_W'(MAX_UNITS) : units_q[c];
		end
		base[0] = '0;
		for (int c = 1; c < NUM_CLASSES; c++) begin
			base[c] = base[c-1] + UNIT_W'(size[c-1]);
		end
	end

	// Decode the item and search the busy map
	always_comb begin
		cls_valid = (cn_q != '0) && (cn_q <= CLASS_W'(NUM_CLASSES));
		cls       = cls_valid ? CLS_W'(cn_q - 1'b1) : '0;
		for (int i = 0; i < MAX_UNITS; i++) begin
			free_bits[i] = !occ_q[cls][i] && (SIZE_W'(i) < size[cls]);
		end
		found    = |free_bits;
		free_idx = '0;
		for (int i = MAX_UNITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
		q_full    = (count_q[cls] == QCNT_W'(QUEUE_DEPTH));
		q_empty   = (count_q[cls] == '0);
		slot_ok   = ({1'b0, slot_q} < size[cls]);
		cls_ofs   = ADDR_W'(cls) * ADDR_W'(QUEUE_DEPTH);
		rd_addr   = cls_ofs + ADDR_W'(head_q[cls]);
		wr_addr   = cls_ofs + ADDR_W'(tail_q[cls]);
		head_next = (head_q[cls] == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q[cls] + 1'b1;
		tail_next = (tail_q[cls] == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q[cls] + 1'b1;

		do_grant = cmd.commit && (op_q == OP_REQUEST) && found;
		do_queue = cmd.commit && (op_q == OP_REQUEST) && !found && !q_full;
		do_free  = cmd.commit && (op_q == OP_RELEASE) && q_empty;
		do_hand  = cmd.commit && (op_q == OP_RELEASE) && !q_empty;

		stat.item_ok   = cls_valid && ((op_q == OP_REQUEST) || slot_ok);
		stat.need_read = (op_q == OP_RELEASE) && !q_empty;
		stat.out_free  = !m_valid_q || m_tready;
	end

	// Capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(s_tuser);
			cn_q   <= s_tdata[CLASS_W-1:0];
			tag_q  <= s_tdata[CLASS_W +: TAG_BITS];
			slot_q <= s_tdata[CLASS_W + TAG_BITS +: SLOT_W];
		end
	end

	// Unit-count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				units_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				if (cfg_we && (cfg_idx == REG_IDX_W'(c))) begin
					units_q[c] <= cfg_wdata;
				end
			end
		end
	end

	// Busy maps and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				occ_q[c]   <= '0;
				head_q[c]  <= '0;
				tail_q[c]  <= '0;
				count_q[c] <= '0;
			end
		end else begin
			if (do_grant) begin
				occ_q[cls][free_idx] <= 1'b1;
			end
			if (do_queue) begin
				tail_q[cls]  <= tail_next;
				count_q[cls] <= count_q[cls] + 1'b1;
			end
			if (do_free) begin
				occ_q[cls][slot_q] <= 1'b0;
			end
			if (do_hand) begin
				occ_q[cls][slot_q] <= 1'b1;
				head_q[cls]        <= head_next;
				count_q[cls]       <= count_q[cls] - 1'b1;
			end
		end
	end

	// Wait-tag memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_queue) begin
			wait_mem[wr_addr] <= tag_q;
		end
		rd_tag_q <= wait_mem[rd_addr];
	end

	// Result valid: set on commit, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (op_q == OP_REQUEST) begin
				res_tag_q <= tag_q;
				if (found) begin
					res_status_q <= ST_GRANTED;
					res_unit_q   <= base[cls] + UNIT_W'(free_idx);
					res_slot_q   <= free_idx;
				end else begin
					res_status_q <= q_full ? ST_FULL : ST_QUEUED;
					res_unit_q   <= '0;
					res_slot_q   <= '0;
				end
			end else begin
				res_status_q <= q_empty ? ST_FREED : ST_HANDED;
				res_tag_q    <= q_empty ? '0 : rd_tag_q;
				res_unit_q   <= base[cls] + UNIT_W'(slot_q);
				res_slot_q   <= slot_q;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = M_DATA_W'({res_slot_q, res_unit_q, res_tag_q});

endmodule

/* rtl/class_pool_allocator_fifo.sv */
// Class pool allocator with per-class FIFO wait queues: top level.
// Instantiates cpa_ctrl and cpa_datapath; depends on cpa_pkg.
//
// Five classes each own the number of units set in their register; units are
// numbered globally in class order. A request beat (s_tuser = 0) is granted
// the lowest free unit of its class, or its tag is queued, or it is refused
// when the queue is full. A release beat (s_tuser = 1) frees the unit or hands
// it to the oldest waiter. Beats with a bad class or an out-of-range slot are
// dropped with no result. One item is worked at a time, from accept through
// evaluation to the result register, with a read state between when a release
// hands its unit to a waiter, whose tag is from a registered read of the tag
// memory. A result that is not taken holds the next item in evaluation. The
// tag memory needs no clearing after reset; busy maps and queues start empty.
module class_pool_allocator_fifo #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 8,
	localparam int S_DATA_W   = ((cpa_pkg::CLASS_W + TAG_BITS + cpa_pkg::SLOT_W + 7) / 8) * 8,
	localparam int M_DATA_W   = ((TAG_BITS + cpa_pkg::UNIT_W + cpa_pkg::SLOT_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [S_DATA_W-1:0]           s_tdata,  // class_number, requester_tag, slot_in_class
	input  logic                          s_tuser,  // op
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [M_DATA_W-1:0]           m_tdata,  // granted_tag, unit_number, slot_granted
	output logic [cpa_pkg::STATUS_W-1:0]  m_tuser,  // status
	// configuration writes
	input  logic                          cfg_we,
	input  logic [cpa_pkg::REG_IDX_W-1:0] cfg_idx,
	input  logic [cpa_pkg::SIZE_W-1:0]    cfg_wdata
);
	import cpa_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	// Sequencer
	cpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Allocation state and result register
	cpa_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS),
		.S_DATA_W    (S_DATA_W),
		.M_DATA_W    (M_DATA_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* bench/class_pool_allocator_fifo_tb.sv */
// Self-checking bench for class_pool_allocator_fifo: directed table, then random phases.
// Depends on cpa_pkg and the RTL top; predicts untyped results with its own model of the pools.
module class_pool_allocator_fifo_tb;
	import cpa_pkg::*;

	localparam int QDEPTH   = 16;
	localparam int WATCHDOG = 2000;
	localparam int DIR_ROWS = 21;

	// One result beat, split into its fields
	typedef struct packed {
		status_t    status;
		logic [7:0] tag;
		logic [6:0] unit;
		logic [3:0] slot;
	} alloc_res_t;

	// One row of the directed table; typed rows carry their own expected result
	typedef struct {
		int          phase;
		op_t         op;
		logic [2:0]  cls;
		logic [7:0]  tag;
		logic [3:0]  slot;
		int          reps;
		bit          typed;
		alloc_res_t  want;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;  // class_number, requester_tag, slot_in_class
	logic        s_tuser   = 1'b0;  // op
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;  // granted_tag, unit_number, slot_granted
	logic [2:0]  m_tuser;  // status
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_idx   = '0;
	logic [4:0]  cfg_wdata = '0;

	// Shadow of the pools
	logic [4:0]  units_q [NUM_CLASSES];
	logic [15:0] busy_q  [NUM_CLASSES];
	logic [7:0]  waitq   [NUM_CLASSES][QDEPTH];
	logic [3:0]  head_q  [NUM_CLASSES];
	logic [3:0]  tail_q  [NUM_CLASSES];
	logic [4:0]  cnt_q   [NUM_CLASSES];

	alloc_res_t expected_q [$];
	alloc_res_t got_res, want_res;
	int         err_cnt     = 0;
	int         idle_cnt    = 0;
	bit         calm        = 1'b0;
	int         stall_asks  = 0;
	int         stall_done  = 0;
	int         rx_hold     = 0;
	int         sz [NUM_CLASSES];

	dir_row_t dir_tab [DIR_ROWS] = '{
		// registers at reset: every class is empty
		'{0, OP_REQUEST, 3'd1, 8'hFF, 4'd0, 1, 1'b1, '{ST_QUEUED, 8'hFF, 7'd0, 4'd0}},
		'{0, OP_REQUEST, 3'd1, 8'h00, 4'd0, 1, 1'b1, '{ST_QUEUED, 8'h00, 7'd0, 4'd0}},
		'{0, OP_RELEASE, 3'd1, 8'h00, 4'd0, 1, 1'b0, '0},
		'{0, OP_REQUEST, 3'd0, 8'h12, 4'd0, 1, 1'b0, '0},
		'{0, OP_REQUEST, 3'd7, 8'h34, 4'd0, 1, 1'b0, '0},
		'{0, OP_RELEASE, 3'd6, 8'h56, 4'd15, 1, 1'b0, '0},
		// sizes 1, 16, 0, 31 (clipped), 2
		'{1, OP_RELEASE, 3'd1, 8'h00, 4'd0, 1, 1'b1, '{ST_HANDED, 8'hFF, 7'd0, 4'd0}},
		'{1, OP_RELEASE, 3'd1, 8'h00, 4'd0, 1, 1'b1, '{ST_HANDED, 8'h00, 7'd0, 4'd0}},
		'{1, OP_RELEASE, 3'd1, 8'hEE, 4'd0, 1, 1'b1, '{ST_FREED, 8'h00, 7'd0, 4'd0}},
		'{1, OP_REQUEST, 3'd1, 8'h5A, 4'd0, 1, 1'b1, '{ST_GRANTED, 8'h5A, 7'd0, 4'd0}},
		'{1, OP_REQUEST, 3'd1, 8'hA5, 4'd0, 1, 1'b1, '{ST_QUEUED, 8'hA5, 7'd0, 4'd0}},
		'{1, OP_RELEASE, 3'd1, 8'h00, 4'd1, 1, 1'b0, '0},
		'{1, OP_REQUEST, 3'd2, 8'h11, 4'd0, 1, 1'b0, '0},
		'{1, OP_REQUEST, 3'd3, 8'h33, 4'd0, 16, 1'b0, '0},
		'{1, OP_REQUEST, 3'd3, 8'hCC, 4'd0, 1, 1'b1, '{ST_FULL, 8'hCC, 7'd0, 4'd0}},
		'{1, OP_RELEASE, 3'd3, 8'h00, 4'd0, 1, 1'b0, '0},
		'{1, OP_REQUEST, 3'd4, 8'h80, 4'd0, 1, 1'b0, '0},
		'{1, OP_RELEASE, 3'd4, 8'h00, 4'd15, 1, 1'b0, '0},
		'{1, OP_REQUEST, 3'd5, 8'h7F, 4'd0, 1, 1'b0, '0},
		'{1, OP_RELEASE, 3'd5, 8'h00, 4'd1, 1, 1'b0, '0},
		'{1, OP_RELEASE, 3'd1, 8'h00, 4'd0, 1, 1'b0, '0}
	};

	class_pool_allocator_fifo DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Units in a class, clipped to the pool width
	function automatic int class_size(input int c);
		return (units_q[c] > MAX_UNITS) ? MAX_UNITS : int'(units_q[c]);
	endfunction

	// Global number of the first unit of a class
	function automatic int class_base(input int c);
		int sum;
		sum = 0;
		for (int i = 0; i < c; i++)
			sum += class_size(i);
		return sum;
	endfunction

	function automatic void clear_pools();
		for (int c = 0; c < NUM_CLASSES; c++) begin
			units_q[c] = '0;
			busy_q[c]  = '0;
			head_q[c]  = '0;
			tail_q[c]  = '0;
			cnt_q[c]   = '0;
		end
	endfunction

	// Advance the shadow pools by one beat; return 1 when the beat yields a result
	function automatic bit predict_alloc(input op_t op, input logic [2:0] cls,
			input logic [7:0] tag, input logic [3:0] slot, output alloc_res_t r);
		int c, size, base;
		r = '0;
		if (cls == 3'd0 || cls > NUM_CLASSES)
			return 1'b0;
		c    = int'(cls) - 1;
		size = class_size(c);
		base = class_base(c);
		if (op == OP_REQUEST) begin
			for (int i = 0; i < size; i++) begin
				if (!busy_q[c][i]) begin
					busy_q[c][i] = 1'b1;
					r.status = ST_GRANTED;
					r.tag    = tag;
					r.unit   = 7'(base + i);
					r.slot   = 4'(i);
					return 1'b1;
				end
			end
			r.tag = tag;
			if (cnt_q[c] >= QDEPTH) begin
				r.status = ST_FULL;
				return 1'b1;
			end
			waitq[c][tail_q[c]] = tag;
			tail_q[c] = 4'((tail_q[c] + 1) % QDEPTH);
			cnt_q[c]  = cnt_q[c] + 5'd1;
			r.status  = ST_QUEUED;
			return 1'b1;
		end
		if (int'(slot) >= size)
			return 1'b0;
		r.unit = 7'(base + int'(slot));
		r.slot = slot;
		if (cnt_q[c] == 0) begin
			busy_q[c][slot] = 1'b0;
			r.status = ST_FREED;
			return 1'b1;
		end
		// hand the unit straight to the oldest waiter
		r.tag     = waitq[c][head_q[c]];
		head_q[c] = 4'((head_q[c] + 1) % QDEPTH);
		cnt_q[c]  = cnt_q[c] - 5'd1;
		busy_q[c][slot] = 1'b1;
		r.status  = ST_HANDED;
		return 1'b1;
	endfunction

	// Offer one beat, hold it until accepted, then predict it
	task automatic offer_beat(input op_t op, input logic [2:0] cls, input logic [7:0] tag,
			input logic [3:0] slot, output bit has, output alloc_res_t r);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, slot, tag, cls};
		do @(posedge clk); while (!s_tready);
		has = predict_alloc(op, cls, tag, slot, r);
	endtask

	// Stop offering, wait for every expected result, then let dropped beats drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all five class sizes, optionally hitting an unused index first
	task automatic write_sizes(input int sizes [NUM_CLASSES], input bit spare);
		if (spare) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= 3'd7;
			cfg_wdata <= 5'd31;
			@(posedge clk);
		end
		for (int i = 0; i < NUM_CLASSES; i++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= 3'(i);
			cfg_wdata <= 5'(sizes[i]);
			@(posedge clk);
			units_q[i] = 5'(sizes[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One setting of the sizes, then n random beats
	task automatic run_phase(input int sizes [NUM_CLASSES], input int n, input int req_pct,
			input bit pressure, input bit spare);
		int         counted, size, v;
		logic [2:0] cls;
		logic [3:0] slot;
		op_t        op;
		bit         has;
		alloc_res_t r;
		write_sizes(sizes, spare);
		if (pressure)
			stall_asks++;
		counted = 0;
		while (counted < n) begin
			if ($urandom_range(0, 19) == 0) begin
				v   = $urandom_range(0, 2);
				cls = (v == 0) ? 3'd0 : 3'(v + 5);
			end else begin
				cls = 3'($urandom_range(1, NUM_CLASSES));
			end
			op   = ($urandom_range(0, 99) < req_pct) ? OP_REQUEST : OP_RELEASE;
			size = (cls >= 1 && cls <= NUM_CLASSES) ? class_size(int'(cls) - 1) : 0;
			if (size > 0 && $urandom_range(0, 99) < 85)
				slot = 4'($urandom_range(0, size - 1));
			else
				slot = 4'($urandom_range(0, 15));
			offer_beat(op, cls, 8'($urandom_range(0, 255)), slot, has, r);
			if (has)
				expected_q.push_back(r);
			counted++;
		end
		settle();
	endtask

	// Receiver: random short stalls, plus one long hold-off when asked
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if (stall_asks != stall_done) begin
			stall_done <= stall_done + 1;
			rx_hold    <= 63;
			m_tready   <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			rx_hold  <= $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = '{status_t'(m_tuser), m_tdata[7:0], m_tdata[14:8], m_tdata[18:15]};
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: %s %0d tag %h unit %0d slot %0d",
					$time, "status", got_res.status, got_res.tag, got_res.unit,
					got_res.slot);
				err_cnt++;
			end else begin
				want_res = expected_q.pop_front();
				if (got_res !== want_res) begin
					$display("%0t: mismatch: expected status %0d tag %h unit %0d slot %0d,",
						$time, want_res.status, want_res.tag, want_res.unit,
						want_res.slot);
					$display("    actual status %0d tag %h unit %0d slot %0d",
						got_res.status, got_res.tag, got_res.unit, got_res.slot);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("%0t: watchdog expired", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int         cur;
		bit         has;
		alloc_res_t r;
		clear_pools();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; the size registers change between its two parts
		cur = 0;
		for (int k = 0; k < DIR_ROWS; k++) begin
			if (dir_tab[k].phase != cur) begin
				settle();
				sz = '{1, 16, 0, 31, 2};
				write_sizes(sz, 1'b0);
				cur = dir_tab[k].phase;
			end
			repeat (dir_tab[k].reps) begin
				offer_beat(dir_tab[k].op, dir_tab[k].cls, dir_tab[k].tag, dir_tab[k].slot, has, r);
				if (dir_tab[k].typed)
					expected_q.push_back(dir_tab[k].want);
				else if (has)
					expected_q.push_back(r);
			end
		end
		settle();

		// Random phases across several size settings
		sz = '{16, 16, 16, 16, 16};
		run_phase(sz, 300, 70, 1'b0, 1'b0);
		sz = '{0, 0, 0, 0, 0};
		run_phase(sz, 150, 80, 1'b0, 1'b0);
		foreach (sz[i]) sz[i] = $urandom_range(0, 31);
		run_phase(sz, 300, 50, 1'b1, 1'b0);
		foreach (sz[i]) sz[i] = $urandom_range(1, 3);
		run_phase(sz, 300, 50, 1'b0, 1'b0);
		foreach (sz[i]) sz[i] = $urandom_range(0, 31);
		run_phase(sz, 300, 45, 1'b0, 1'b1);
		calm = 1'b1;
		sz = '{16, 0, 31, 1, 16};
		run_phase(sz, 300, 50, 1'b0, 1'b0);

		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
rtl/cpa_pkg.sv
rtl/cpa_ctrl.sv
rtl/cpa_datapath.sv
rtl/class_pool_allocator_fifo.sv
bench/class_pool_allocator_fifo_tb.sv
